// File: design/ssx_pkg.sv
// Shared constants and types for the selection sampler.
package ssx_pkg;

  // Width of the record and pick counters
  localparam int COUNT_WIDTH = 24;
  // Width kept by the mask applied to size register writes
  localparam int SIZE_WIDTH  = 24;
  localparam int DATA_WIDTH  = 64;

  // Size registers keep their low SIZE_WIDTH bits, then COUNT_WIDTH bits
  localparam logic [DATA_WIDTH-1:0] SIZE_MASK = (64'd1 << SIZE_WIDTH) - 64'd1;
  localparam logic [COUNT_WIDTH-1:0] CFG_MASK = COUNT_WIDTH'(SIZE_MASK);

  // Remainder unit: two dividend bits per cycle
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS         = DATA_WIDTH / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  // Generator rotation and shift amounts
  localparam int ROT_A   = 24;
  localparam int SHIFT_B = 16;
  localparam int ROT_C   = 37;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SAMPLE_SIZE     = 2'd0,
    CFG_POPULATION_SIZE = 2'd1,
    CFG_SEED_ZERO       = 2'd2,
    CFG_SEED_ONE        = 2'd3
  } cfg_index_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage

// File: design/ssx_divider.sv
// Iterative remainder unit: 64-bit dividend modulo a count-wide divisor.
module ssx_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ssx_pkg::DATA_WIDTH-1:0]     dividend,
  input  logic [ssx_pkg::COUNT_WIDTH-1:0]    divisor,
  output logic                               done,
  output logic [ssx_pkg::COUNT_WIDTH-1:0]    remainder
);

  logic [ssx_pkg::DATA_WIDTH-1:0]  dividend_sh;
  logic [ssx_pkg::COUNT_WIDTH-1:0] divisor_q;
  logic [ssx_pkg::COUNT_WIDTH-1:0] rem;
  logic [ssx_pkg::COUNT_WIDTH-1:0] rem_mid;
  logic [ssx_pkg::COUNT_WIDTH-1:0] rem_next;
  logic [ssx_pkg::DIV_CNT_W-1:0]   cnt;
  logic                            busy;

  // One restoring step: bring in one bit, subtract if it fits
  function automatic logic [ssx_pkg::COUNT_WIDTH-1:0] rem_step(
    input logic [ssx_pkg::COUNT_WIDTH-1:0] r,
    input logic                            b,
    input logic [ssx_pkg::COUNT_WIDTH-1:0] d
  );
    logic [ssx_pkg::COUNT_WIDTH:0] t;
    logic [ssx_pkg::COUNT_WIDTH:0] dx;
    t  = {r, b};
    dx = {1'b0, d};
    if (t >= dx) begin
      return ssx_pkg::COUNT_WIDTH'(t - dx);
    end
    return ssx_pkg::COUNT_WIDTH'(t);
  endfunction

  // Two chained steps per cycle, most significant bits first
  always_comb begin
    rem_mid  = rem_step(rem, dividend_sh[ssx_pkg::DATA_WIDTH-1], divisor_q);
    rem_next = rem_step(rem_mid, dividend_sh[ssx_pkg::DATA_WIDTH-2], divisor_q);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ssx_pkg::DIV_CNT_W'(ssx_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dividend_sh <= dividend;
      divisor_q   <= divisor;
      rem         <= '0;
    end else if (busy) begin
      dividend_sh <= dividend_sh << ssx_pkg::DIV_BITS_PER_STEP;
      rem         <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// File: design/selection_sampler_xoroshiro_core.sv
// Selection sampler top level: picks a uniform sample from a record stream.
//
// Records are accepted only while the sequencer is idle. A record that takes
// part in the draw (sample not yet complete, pass not yet exhausted) then
// occupies the block: it is accepted and steps the generator, then the shared
// remainder unit works (two dividend bits per cycle over a 64-bit draw), then
// the unit flags completion, then the block decides and loads the output
// register; the output register can hold a pick while the next record is
// taken, but a new pick waits until it is free. Records that take no part in
// the draw are taken every cycle while the block is idle. A record with tuser
// set starts a new pass. Writing a seed register reloads the generator.
module selection_sampler_xoroshiro_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input records
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] record_value
  input  logic        s_tuser,   // [0] first_record
  // picked records
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [63:0] selected_value, [87:64] sample_position
  output logic        m_tlast    // sample_done
);

  localparam int CW = ssx_pkg::COUNT_WIDTH;

  ssx_pkg::state_t state, state_next;

  logic [63:0]   gen_w0;
  logic [63:0]   gen_w1;
  logic [63:0]   gen_w0_next;
  logic [63:0]   gen_w1_next;
  logic [63:0]   gen_mix;
  logic [63:0]   draw;

  logic [CW-1:0] sample_size;
  logic [CW-1:0] population_size;
  logic [CW-1:0] records_seen;
  logic [CW-1:0] picks_made;
  logic [CW-1:0] seen_eff;
  logic [CW-1:0] picks_eff;
  logic [CW-1:0] remaining;
  logic [CW-1:0] needed;
  logic [CW-1:0] hold_needed;
  logic [63:0]   hold_record;

  logic [63:0]   out_value;
  logic [23:0]   out_pos;
  logic          out_last;

  logic          accept;
  logic          has_work;
  logic          picked;
  logic          slot_free;
  logic          out_load;
  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_rem;

  // Pass bookkeeping as seen by the offered record
  always_comb begin
    seen_eff  = s_tuser ? '0 : records_seen;
    picks_eff = s_tuser ? '0 : picks_made;
    has_work  = (picks_eff < sample_size) && (seen_eff < population_size);
    remaining = population_size - seen_eff;
    needed    = sample_size - picks_eff;
  end

  // Generator step
  always_comb begin
    draw        = gen_w0 + gen_w1;
    gen_mix     = gen_w1 ^ gen_w0;
    gen_w0_next = {gen_w0[63-ssx_pkg::ROT_A:0], gen_w0[63:64-ssx_pkg::ROT_A]}
                  ^ gen_mix ^ (gen_mix << ssx_pkg::SHIFT_B);
    gen_w1_next = {gen_mix[63-ssx_pkg::ROT_C:0], gen_mix[63:64-ssx_pkg::ROT_C]};
  end

  assign accept    = s_tvalid && s_tready;
  assign picked    = div_rem < hold_needed;
  assign slot_free = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ssx_pkg::ST_IDLE: begin
        if (accept && has_work) begin
          state_next = ssx_pkg::ST_DIVIDE;
        end
      end
      ssx_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = ssx_pkg::ST_EMIT;
        end
      end
      ssx_pkg::ST_EMIT: begin
        if (!picked || slot_free) begin
          state_next = ssx_pkg::ST_IDLE;
        end
      end
      default: state_next = ssx_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ssx_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        div_start = s_tvalid && has_work;
      end
      ssx_pkg::ST_DIVIDE: begin
      end
      ssx_pkg::ST_EMIT: begin
        out_load = picked && slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters, generator and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_size     <= '0;
      population_size <= '0;
      gen_w0          <= 64'd1;
      gen_w1          <= 64'd0;
      records_seen    <= '0;
      picks_made      <= '0;
    end else begin
      if (accept) begin
        picks_made   <= picks_eff;
        records_seen <= has_work ? seen_eff + 1'b1 : seen_eff;
        if (has_work) begin
          gen_w0 <= gen_w0_next;
          gen_w1 <= gen_w1_next;
        end
      end
      if (out_load) begin
        picks_made <= picks_made + 1'b1;
      end
      if (cfg_we) begin
        unique case (ssx_pkg::cfg_index_t'(cfg_index))
          ssx_pkg::CFG_SAMPLE_SIZE:
            sample_size <= cfg_data[CW-1:0] & ssx_pkg::CFG_MASK;
          ssx_pkg::CFG_POPULATION_SIZE:
            population_size <= cfg_data[CW-1:0] & ssx_pkg::CFG_MASK;
          ssx_pkg::CFG_SEED_ZERO:
            gen_w0 <= cfg_data;
          ssx_pkg::CFG_SEED_ONE:
            gen_w1 <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Record and threshold held while the remainder is worked out
  always_ff @(posedge clk) begin
    if (div_start) begin
      hold_record <= s_tdata;
      hold_needed <= needed;
    end
  end

  ssx_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (draw),
    .divisor   (remaining),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= hold_record;
      out_pos   <= 24'(picks_made);
      out_last  <= (hold_needed == CW'(1));
    end
  end

  assign m_tdata = {out_pos, out_value};
  assign m_tlast = out_last;

  // Checks
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ssx_pkg::ST_DIVIDE)
    else $error("remainder unit finished outside the divide state");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    div_start |=> ##32 (div_done && div_rem < $past(remaining, 33)))
    else $error("remainder not ready or not below divisor after 32 steps");

  a_no_load_while_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> !(m_tvalid && $changed(m_tdata) && !$past(out_load)))
    else $error("output changed without a load");

endmodule
